[design/assert_macros.svh]
// Assertion macros shared by the colour classifier RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLY(label, cond, expr)
`endif
`endif

[design/bwcc_pkg.sv]
// Types and constants for the calibrated RGB colour classifier.
// No dependencies; every other design module imports this package.
package bwcc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DEN_W       = SAMPLE_BITS + 2;
  localparam int REM_W       = SAMPLE_BITS + 8;
  localparam int CMP_W       = DEN_W + 8;

  localparam logic [7:0] FULL_SCALE  = 8'd255;
  localparam logic [7:0] BLACK_MAX   = 8'd30;
  localparam logic [7:0] WHITE_MIN   = 8'd230;
  localparam logic [7:0] GRAY_SPREAD = 8'd20;

  // Colour class codes.
  localparam logic [2:0] CLS_BLACK = 3'd0;
  localparam logic [2:0] CLS_WHITE = 3'd1;
  localparam logic [2:0] CLS_GRAY  = 3'd2;
  localparam logic [2:0] CLS_RED   = 3'd3;
  localparam logic [2:0] CLS_GREEN = 3'd4;
  localparam logic [2:0] CLS_BLUE  = 3'd5;

  // Register indexes.
  localparam logic [2:0] REG_CAL_VALID   = 3'd0;
  localparam logic [2:0] REG_RED_BLACK   = 3'd1;
  localparam logic [2:0] REG_RED_WHITE   = 3'd2;
  localparam logic [2:0] REG_GREEN_BLACK = 3'd3;
  localparam logic [2:0] REG_GREEN_WHITE = 3'd4;
  localparam logic [2:0] REG_BLUE_BLACK  = 3'd5;
  localparam logic [2:0] REG_BLUE_WHITE  = 3'd6;

  // How a channel result is formed at the end of the pipe.
  localparam logic [1:0] CH_DIV  = 2'd0;
  localparam logic [1:0] CH_ZERO = 2'd1;
  localparam logic [1:0] CH_FULL = 2'd2;

  typedef struct packed {
    logic [15:0] raw_red;
    logic [15:0] raw_green;
    logic [15:0] raw_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] norm_red;
    logic [7:0] norm_green;
    logic [7:0] norm_blue;
    logic [2:0] color_class;
  } out_item_t;

  typedef struct packed {
    logic                         cal_valid;
    logic [2:0][SAMPLE_BITS-1:0] black;
    logic [2:0][SAMPLE_BITS-1:0] white;
  } cal_cfg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [7:0]       quo;
  } chan_t;

endpackage

[design/bwcc_front.sv]
// Front end: clamps against calibration or forms the channel sum, then
// builds numerator times full scale. Two register stages. Uses bwcc_pkg.
module bwcc_front import bwcc_pkg::*; (
  input  logic               clk,
  input  logic               en_a,
  input  logic               en_b,
  input  in_item_t           in_data,
  input  cal_cfg_t           cfg,
  output chan_t [2:0]        ch
);

  logic [2:0][SAMPLE_BITS-1:0] raw;
  logic [2:0][1:0]             mode_c;
  logic [2:0][SAMPLE_BITS-1:0] num_c;
  logic [2:0][DEN_W-1:0]       den_c;
  logic [DEN_W-1:0]            sum;

  logic [2:0][1:0]             a_mode;
  logic [2:0][SAMPLE_BITS-1:0] a_num;
  logic [2:0][DEN_W-1:0]       a_den;

  assign raw[0] = in_data.raw_red;
  assign raw[1] = in_data.raw_green;
  assign raw[2] = in_data.raw_blue;
  assign sum = DEN_W'(raw[0]) + DEN_W'(raw[1]) + DEN_W'(raw[2]);

  // Per-channel operand selection.
  always_comb begin
    logic [SAMPLE_BITS-1:0] lo, hi, v;
    for (int i = 0; i < 3; i++) begin
      lo = cfg.black[i];
      hi = cfg.white[i];
      v  = raw[i];
      mode_c[i] = CH_DIV;
      num_c[i]  = raw[i];
      den_c[i]  = sum;
      if (cfg.cal_valid) begin
        if (lo == hi) begin
          mode_c[i] = CH_ZERO;
        end else if (lo > hi) begin
          mode_c[i] = (raw[i] < lo) ? CH_ZERO : CH_FULL;
        end else begin
          if (raw[i] < lo) v = lo;
          else if (raw[i] > hi) v = hi;
          num_c[i] = v - lo;
          den_c[i] = DEN_W'(hi - lo);
        end
      end else if (sum == '0) begin
        mode_c[i] = CH_ZERO;
      end
    end
  end

  // First stage register.
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_mode <= mode_c;
      a_num  <= num_c;
      a_den  <= den_c;
    end
  end

  // Second stage: numerator times 255 as a shift and subtract.
  always_ff @(posedge clk) begin
    if (en_b) begin
      for (int i = 0; i < 3; i++) begin
        ch[i].mode <= a_mode[i];
        ch[i].rem  <= {a_num[i], 8'd0} - REM_W'(a_num[i]);
        ch[i].den  <= a_den[i];
        ch[i].quo  <= '0;
      end
    end
  end

endmodule

[design/bwcc_div_step.sv]
// One restoring-division stage: two quotient bits for each of three channels.
// Uses bwcc_pkg; BIT_HI selects which quotient bits this stage settles.
module bwcc_div_step import bwcc_pkg::*; #(
  parameter int BIT_HI = 7
) (
  input  logic        clk,
  input  logic        en,
  input  chan_t [2:0] ch_in,
  output chan_t [2:0] ch_out
);

  localparam int K0 = BIT_HI;
  localparam int K1 = BIT_HI - 1;

  chan_t [2:0] ch_c;

  // Trial subtraction of the shifted divisor, high bit first.
  always_comb begin
    logic [CMP_W-1:0] r, s0, s1;
    for (int i = 0; i < 3; i++) begin
      ch_c[i] = ch_in[i];
      r  = CMP_W'(ch_in[i].rem);
      s0 = CMP_W'(ch_in[i].den) << K0;
      s1 = CMP_W'(ch_in[i].den) << K1;
      if (r >= s0) begin
        r = r - s0;
        ch_c[i].quo = ch_c[i].quo | (8'd1 << K0);
      end
      if (r >= s1) begin
        r = r - s1;
        ch_c[i].quo = ch_c[i].quo | (8'd1 << K1);
      end
      ch_c[i].rem = r[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) ch_out <= ch_c;
  end

endmodule

[design/bwcc_classify.sv]
// Final stage: resolves channel values and picks the colour class.
// Holds the output register. Uses bwcc_pkg.
module bwcc_classify import bwcc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  chan_t [2:0] ch,
  output out_item_t   out_data
);

  logic [2:0][7:0] nv;
  logic [7:0]      mx, mn, d;
  logic [2:0]      cls;

  // Channel value from its mode.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (ch[i].mode)
        CH_ZERO: nv[i] = 8'd0;
        CH_FULL: nv[i] = FULL_SCALE;
        default: nv[i] = ch[i].quo;
      endcase
    end
  end

  // Spread of the channels and class decision.
  always_comb begin
    mx = nv[0];
    mn = nv[0];
    if (nv[1] > mx) mx = nv[1];
    if (nv[2] > mx) mx = nv[2];
    if (nv[1] < mn) mn = nv[1];
    if (nv[2] < mn) mn = nv[2];
    d = mx - mn;
    priority if (mx < BLACK_MAX) cls = CLS_BLACK;
    else if (mx > WHITE_MIN && d < GRAY_SPREAD) cls = CLS_WHITE;
    else if (d < GRAY_SPREAD) cls = CLS_GRAY;
    else if (nv[0] >= nv[1] && nv[0] >= nv[2]) cls = CLS_RED;
    else if (nv[1] >= nv[0] && nv[1] >= nv[2]) cls = CLS_GREEN;
    else cls = CLS_BLUE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.norm_red    <= nv[0];
      out_data.norm_green  <= nv[1];
      out_data.norm_blue   <= nv[2];
      out_data.color_class <= cls;
    end
  end

endmodule

[design/rgb_calibrated_color_classifier.sv]
// Calibrated RGB colour classifier, top level.
// Input channel: in_valid / in_stall / in_data carries one raw sample request;
// it is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall / out_data carries the three
// normalised channels and the colour class, one result per request.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 cal_valid, 1..6 black/white limits per channel); other indexes are
// ignored. Write only while the pipe is empty.
// A request passes two front stages, four division stages settling two
// quotient bits each, and the class stage with the output register.
// Throughput is one request per cycle while out_stall is low.
// Each stage moves on when the stage after it is empty or moving, so
// bubbles close up; when out_stall is held the pipe fills and in_stall
// rises once all seven stages hold a request. Reset clears all valid
// bits and sets every configuration register to zero.
`include "assert_macros.svh"
module rgb_calibrated_color_classifier import bwcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NSTG = 7;

  cal_cfg_t          cfg;
  logic [NSTG-1:0]   pipe_v;
  logic [NSTG-1:0]   rdy;
  chan_t [2:0]       ch_f;
  chan_t [2:0]       ch_d [5];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_VALID:   cfg.cal_valid <= cfg_data[0];
        REG_RED_BLACK:   cfg.black[0]  <= cfg_data[SAMPLE_BITS-1:0];
        REG_RED_WHITE:   cfg.white[0]  <= cfg_data[SAMPLE_BITS-1:0];
        REG_GREEN_BLACK: cfg.black[1]  <= cfg_data[SAMPLE_BITS-1:0];
        REG_GREEN_WHITE: cfg.white[1]  <= cfg_data[SAMPLE_BITS-1:0];
        REG_BLUE_BLACK:  cfg.black[2]  <= cfg_data[SAMPLE_BITS-1:0];
        REG_BLUE_WHITE:  cfg.white[2]  <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when it is empty or its contents move on.
  always_comb begin
    rdy[NSTG-1] = !pipe_v[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !pipe_v[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else begin
      if (rdy[0]) pipe_v[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) pipe_v[i] <= pipe_v[i-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = pipe_v[NSTG-1];

  bwcc_front u_front (
    .clk     (clk),
    .en_a    (rdy[0]),
    .en_b    (rdy[1]),
    .in_data (in_data),
    .cfg     (cfg),
    .ch      (ch_f)
  );

  assign ch_d[0] = ch_f;

  // Division stages, two quotient bits each.
  for (genvar s = 0; s < 4; s++) begin : g_div
    bwcc_div_step #(.BIT_HI(7 - 2 * s)) u_div (
      .clk    (clk),
      .en     (rdy[2+s]),
      .ch_in  (ch_d[s]),
      .ch_out (ch_d[s+1])
    );
  end

  bwcc_classify u_cls (
    .clk      (clk),
    .en       (rdy[NSTG-1]),
    .ch       (ch_d[4]),
    .out_data (out_data)
  );

  // Checks.
  `ASSERT_IMPLY(a_stall_full, in_stall, out_valid && out_stall && (&pipe_v))
  `ASSERT_IMPLY(a_black_dark, out_valid && out_data.color_class == CLS_BLACK,
                out_data.norm_red < BLACK_MAX && out_data.norm_green < BLACK_MAX)
  `ASSERT_IMPLY(a_white_bright, out_valid && out_data.color_class == CLS_WHITE,
                out_data.norm_red > WHITE_MIN - GRAY_SPREAD)

endmodule

[dv/rgb_calibrated_color_classifier_tb.sv]
// Self-checking testbench for the calibrated RGB colour classifier.
// Depends on bwcc_pkg and the rgb_calibrated_color_classifier top level.
`timescale 1ns / 100ps
module rgb_calibrated_color_classifier_tb;
  import bwcc_pkg::*;

  localparam int LATENCY    = 7;
  localparam int WDOG_LIMIT = 4000;
  localparam int HOLD_LEN   = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Local copy of the calibration registers.
  logic        cal_on;
  logic [15:0] blk [3];
  logic [15:0] wht [3];

  out_item_t   colour_queue [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          sent = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  // Directed rows: raw sample and, where obvious, the expected result.
  typedef struct {
    in_item_t  smp;
    bit        known;
    out_item_t res;
  } row_t;

  always #6 clk = ~clk;

  rgb_calibrated_color_classifier DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  // Linear map of one channel between its black and white readings.
  function automatic logic [7:0] map_cal(logic [15:0] x, logic [15:0] lo,
                                         logic [15:0] hi);
    longint v;
    longint q;
    if (lo == hi) return 8'd0;
    if (x < lo) v = lo;
    else if (x > hi) v = hi;
    else v = x;
    q = ((v - longint'(lo)) * 255) / (longint'(hi) - longint'(lo));
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // Full colour prediction for one sample under the current calibration.
  function automatic out_item_t predict_colour(in_item_t s);
    out_item_t o;
    longint    sum;
    logic [7:0] mx, mn, d;
    if (cal_on) begin
      o.norm_red   = map_cal(s.raw_red, blk[0], wht[0]);
      o.norm_green = map_cal(s.raw_green, blk[1], wht[1]);
      o.norm_blue  = map_cal(s.raw_blue, blk[2], wht[2]);
    end else begin
      sum = longint'(s.raw_red) + s.raw_green + s.raw_blue;
      if (sum == 0) begin
        o.norm_red = 0; o.norm_green = 0; o.norm_blue = 0;
      end else begin
        o.norm_red   = 8'((longint'(s.raw_red) * 255) / sum);
        o.norm_green = 8'((longint'(s.raw_green) * 255) / sum);
        o.norm_blue  = 8'((longint'(s.raw_blue) * 255) / sum);
      end
    end
    mx = o.norm_red; mn = o.norm_red;
    if (o.norm_green > mx) mx = o.norm_green;
    if (o.norm_blue > mx) mx = o.norm_blue;
    if (o.norm_green < mn) mn = o.norm_green;
    if (o.norm_blue < mn) mn = o.norm_blue;
    d = mx - mn;
    if (mx < BLACK_MAX) o.color_class = CLS_BLACK;
    else if (mx > WHITE_MIN && d < GRAY_SPREAD) o.color_class = CLS_WHITE;
    else if (d < GRAY_SPREAD) o.color_class = CLS_GRAY;
    else if (o.norm_red >= o.norm_green && o.norm_red >= o.norm_blue)
      o.color_class = CLS_RED;
    else if (o.norm_green >= o.norm_blue) o.color_class = CLS_GREEN;
    else o.color_class = CLS_BLUE;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Register write; the local copy follows the same masking. The caller
  // drops the write enable after the last write of a sequence.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_CAL_VALID:   cal_on = val[0];
      REG_RED_BLACK:   blk[0] = val;
      REG_RED_WHITE:   wht[0] = val;
      REG_GREEN_BLACK: blk[1] = val;
      REG_GREEN_WHITE: wht[1] = val;
      REG_BLUE_BLACK:  blk[2] = val;
      REG_BLUE_WHITE:  wht[2] = val;
      default: ;
    endcase
  endtask

  task automatic write_cal(logic on, logic [15:0] rb, logic [15:0] rw,
                           logic [15:0] gb, logic [15:0] gw,
                           logic [15:0] bb, logic [15:0] bw);
    write_reg(REG_CAL_VALID, {15'd0, on});
    write_reg(REG_RED_BLACK, rb);   write_reg(REG_RED_WHITE, rw);
    write_reg(REG_GREEN_BLACK, gb); write_reg(REG_GREEN_WHITE, gw);
    write_reg(REG_BLUE_BLACK, bb);  write_reg(REG_BLUE_WHITE, bw);
    cfg_we <= 1'b0;
  endtask

  // Offer one request, idling at random beforehand, and hold it until taken.
  task automatic send_sample(in_item_t s);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    colour_queue.push_back(predict_colour(s));
    sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait for the pipe to drain before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(4000));
      2: return 16'($urandom_range(65535, 60000));
      default: return 16'($urandom_range(400, 100));
    endcase
  endfunction

  // Receiver: random stall, with one long hold-off on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_LEN; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= (!calm && $urandom_range(99) < 23);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 colour_queue.size());
        $display("FAILED: results differ");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (colour_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = colour_queue.pop_front();
          if (out_data.norm_red != want.norm_red)
            report_mismatch("norm_red", out_data.norm_red, want.norm_red);
          if (out_data.norm_green != want.norm_green)
            report_mismatch("norm_green", out_data.norm_green, want.norm_green);
          if (out_data.norm_blue != want.norm_blue)
            report_mismatch("norm_blue", out_data.norm_blue, want.norm_blue);
          if (out_data.color_class != want.color_class)
            report_mismatch("color_class", out_data.color_class,
                            want.color_class);
        end
        results_seen++;
      end
    end
  end

  // Stimulus.
  initial begin
    row_t      rows [$];
    row_t      r;
    out_item_t p;
    int        i, k, ph, t;
    cal_on = 0;
    for (i = 0; i < 3; i++) begin blk[i] = 0; wht[i] = 0; end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fallback after reset: zero sum, single channels, full-scale grey.
    rows.push_back('{'{16'd0, 16'd0, 16'd0}, 1, '{8'd0, 8'd0, 8'd0, CLS_BLACK}});
    rows.push_back('{'{16'hFFFF, 16'd0, 16'd0}, 1, '{8'd255, 8'd0, 8'd0, CLS_RED}});
    rows.push_back('{'{16'd0, 16'hFFFF, 16'd0}, 1, '{8'd0, 8'd255, 8'd0, CLS_GREEN}});
    rows.push_back('{'{16'd0, 16'd0, 16'hFFFF}, 1, '{8'd0, 8'd0, 8'd255, CLS_BLUE}});
    rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, '0});
    rows.push_back('{'{16'd1, 16'd1, 16'd0}, 0, '0});
    rows.push_back('{'{16'hAAAA, 16'h5555, 16'h0F0F}, 0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      p = predict_colour(r.smp);
      if (r.known && p != r.res) report_mismatch("directed row", i, -1);
      send_sample(r.smp);
    end
    drain();

    // Calibrated: normal limits, equal limits, black above white.
    write_cal(1'b1, 16'd100, 16'd1000, 16'd500, 16'd500, 16'hFFFF, 16'd0);
    rows.delete();
    rows.push_back('{'{16'd0, 16'd0, 16'd0}, 1, '{8'd0, 8'd0, 8'd0, CLS_BLACK}});
    rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1,
                     '{8'd255, 8'd0, 8'd255, CLS_RED}});
    rows.push_back('{'{16'd1000, 16'd500, 16'd0}, 1, '{8'd255, 8'd0, 8'd0, CLS_RED}});
    rows.push_back('{'{16'd550, 16'd7, 16'hFFFF}, 0, '0});
    rows.push_back('{'{16'd101, 16'd499, 16'hFFFE}, 0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      p = predict_colour(r.smp);
      if (r.known && p != r.res) report_mismatch("calibrated row", i, -1);
      send_sample(r.smp);
    end
    drain();
    write_cal(1'b1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_sample('{16'hFFFF, 16'h8000, 16'd0});
    send_sample('{16'd1, 16'hFFFF, 16'hFFFE});
    drain();
    // Index beyond the list must be ignored.
    write_reg(3'd7, 16'hFFFF);
    cfg_we <= 1'b0;

    // Random phases, each under a fresh setting.
    for (ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_cal(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: write_cal(1'b1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        default: begin
          for (k = 0; k < 7; k++) write_reg(k[2:0], rand_raw());
          write_reg(REG_CAL_VALID, 16'($urandom_range(65535)) | 16'd1);
          cfg_we <= 1'b0;
        end
      endcase
      calm = (ph == 2);
      for (t = 0; t < 80; t++) begin
        if (ph == 3 && t == 10) hold_req = 1'b1;
        send_sample('{rand_raw(), rand_raw(), rand_raw()});
      end
      calm = 1'b0;
    end
    drain();

    $display("%0d requests sent, %0d results checked over fallback and",
             sent, results_seen);
    $display("calibrated settings including equal and inverted limits");
    if (mismatches == 0 && colour_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/bwcc_pkg.sv
design/bwcc_front.sv
design/bwcc_div_step.sv
design/bwcc_classify.sv
design/rgb_calibrated_color_classifier.sv
dv/rgb_calibrated_color_classifier_tb.sv
